// ===== hdl/tme_pkg.sv =====
// Shared constants for the tape machine instruction executor.
`default_nettype none
package tme_pkg;

  // Storage sizes and widths
  localparam int unsigned ProgDepth  = 4096;
  localparam int unsigned TapeDepth  = 4096;
  localparam int unsigned QueueDepth = 16;
  localparam int unsigned ProgAw     = 12;
  localparam int unsigned TapeAw     = 12;
  localparam int unsigned QueueAw    = 4;
  localparam int unsigned LenW       = 13;

  // Item operations
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_QUEUE = 2'd1;
  localparam logic [1:0] OP_EXEC  = 2'd2;

  // Result events
  localparam logic [2:0] EV_DONE = 3'd0;
  localparam logic [2:0] EV_OUT  = 3'd1;
  localparam logic [2:0] EV_END  = 3'd2;
  localparam logic [2:0] EV_HALT = 3'd3;
  localparam logic [2:0] EV_JUMP = 3'd4;
  localparam logic [2:0] EV_WAIT = 3'd5;
  localparam logic [2:0] EV_FULL = 3'd6;

  // Fixed instruction bytes
  localparam logic [7:0] INS_INC   = 8'h2B;
  localparam logic [7:0] INS_DEC   = 8'h2D;
  localparam logic [7:0] INS_RIGHT = 8'h3E;
  localparam logic [7:0] INS_LEFT  = 8'h3C;
  localparam logic [7:0] INS_OUT   = 8'h2E;
  localparam logic [7:0] INS_IN    = 8'h2C;
  localparam logic [7:0] INS_OPEN  = 8'h5B;
  localparam logic [7:0] INS_CLOSE = 8'h5D;

  // Configuration register indexes
  localparam logic [2:0] REG_WRAP  = 3'd0;
  localparam logic [2:0] REG_EXT   = 3'd1;
  localparam logic [2:0] REG_SIZE  = 3'd2;
  localparam logic [2:0] REG_COPY0 = 3'd3;
  localparam logic [2:0] REG_COPY1 = 3'd4;
  localparam logic [2:0] REG_STOP  = 3'd5;
  localparam logic [2:0] REG_PCLR  = 3'd6;
  localparam logic [2:0] REG_PSWAP = 3'd7;

endpackage
`default_nettype wire

// ===== hdl/tape_machine_instruction_executor.sv =====
// Top level: byte-tape machine with program store, tape and input queue.
//
// Usage. An input word carries op, address and value and is taken when
// in_valid is high and in_stall low. Op load writes a program byte, op queue
// pushes an input byte, op execute runs the instruction at the program
// counter. Every word yields exactly one result word on the out_ channel,
// taken when out_valid is high and out_stall low. Configuration words arrive
// on the cfg_ channel, which is always ready; write it only while idle.
// Sequence: load, queue, the unused op and end of program go from accept
// through ST_RESP to out_valid; an executed instruction passes ST_EXEC
// first, and a bracket jump then scans the program one byte at a time
// through ST_SRD and ST_SCHK, using the single program store read port and
// the shared scan step. A new word is accepted only after the last one has
// left ST_RESP; in_stall is high until then.
// Reset: synchronous, active low. Afterwards all 4096 tape cells are cleared
// one cell a cycle, during which in_stall stays high.
// When the receiver stalls, the result is held in the output register and
// the next result waits in the block until that register is free.
`default_nettype none
module tape_machine_instruction_executor (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_op,
  input  wire logic [11:0] in_address,
  input  wire logic [7:0]  in_value,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_event_res,
  output logic [7:0]       out_data,
  output logic [12:0]      out_error_position,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [12:0] cfg_data
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CLR  = 3'd1;
  localparam logic [2:0] ST_EXEC = 3'd2;
  localparam logic [2:0] ST_SRD  = 3'd3;
  localparam logic [2:0] ST_SCHK = 3'd4;
  localparam logic [2:0] ST_RESP = 3'd5;

  localparam logic [12:0] TapeFull = 13'(tme_pkg::TapeDepth);

  // Control and configuration registers
  logic [2:0]  state_r, state_nxt;
  logic [11:0] clr_r, clr_nxt;
  logic [12:0] pc_r, pc_nxt;
  logic [12:0] len_r, len_nxt;
  logic [11:0] dp_r, dp_nxt;
  logic [11:0] sp_r, sp_nxt;
  logic [3:0]  head_r, head_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [12:0] scan_p_r, scan_p_nxt;
  logic [12:0] scan_dep_r, scan_dep_nxt;
  logic        scan_fwd_r, scan_fwd_nxt;
  logic [2:0]  res_ev_r, res_ev_nxt;
  logic [7:0]  res_data_r, res_data_nxt;
  logic [12:0] res_epos_r, res_epos_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [2:0]  out_ev_r, out_ev_nxt;
  logic [7:0]  out_data_r, out_data_nxt;
  logic [12:0] out_epos_r, out_epos_nxt;
  logic        wrap_r, ext_r;
  logic [12:0] tsize_r;
  logic [7:0]  copy0_r, copy1_r, stop_r, pclr_r, pswap_r;

  // Memories and queue
  logic [7:0]  pm [tme_pkg::ProgDepth];
  logic [7:0]  tape [tme_pkg::TapeDepth];
  logic [7:0]  q_r [tme_pkg::QueueDepth];
  logic [7:0]  pm_rdata_r, tp_rdata_r;
  logic        pm_we, tp_we, q_we;
  logic [11:0] pm_raddr, tp_waddr;
  logic [7:0]  tp_wdata;

  // Working values
  logic        in_acc;
  logic [12:0] size_eff;
  logic [11:0] size_m1;
  logic [7:0]  ins, cur_cell, sb;
  logic [12:0] step_p, dep_new;

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid          = out_valid_r;
  assign out_event_res      = out_ev_r;
  assign out_data           = out_data_r;
  assign out_error_position = out_epos_r;

  // Tape size in use, clamped to the physical depth, with zero taken as one
  always_comb begin
    if (tsize_r == 13'd0) begin
      size_eff = 13'd1;
    end else if (tsize_r > TapeFull) begin
      size_eff = TapeFull;
    end else begin
      size_eff = tsize_r;
    end
    size_m1 = 12'(size_eff - 13'd1);
  end

  assign ins      = pm_rdata_r;
  assign cur_cell = tp_rdata_r;
  assign sb       = pm_rdata_r;

  // Shared scan unit: position step and nesting depth update
  always_comb begin
    step_p = scan_fwd_r ? (scan_p_r + 13'd1) : (scan_p_r - 13'd1);
    dep_new = scan_dep_r;
    if ((sb == tme_pkg::INS_OPEN && scan_fwd_r) ||
        (sb == tme_pkg::INS_CLOSE && !scan_fwd_r)) begin
      dep_new = scan_dep_r + 13'd1;
    end else if ((sb == tme_pkg::INS_CLOSE && scan_fwd_r) ||
                 (sb == tme_pkg::INS_OPEN && !scan_fwd_r)) begin
      dep_new = scan_dep_r - 13'd1;
    end
  end

  // Sequencer
  always_comb begin
    state_nxt    = state_r;
    clr_nxt      = clr_r;
    pc_nxt       = pc_r;
    len_nxt      = len_r;
    dp_nxt       = dp_r;
    sp_nxt       = sp_r;
    head_nxt     = head_r;
    cnt_nxt      = cnt_r;
    scan_p_nxt   = scan_p_r;
    scan_dep_nxt = scan_dep_r;
    scan_fwd_nxt = scan_fwd_r;
    res_ev_nxt   = res_ev_r;
    res_data_nxt = res_data_r;
    res_epos_nxt = res_epos_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_ev_nxt   = out_ev_r;
    out_data_nxt = out_data_r;
    out_epos_nxt = out_epos_r;
    pm_we    = 1'b0;
    pm_raddr = pc_r[11:0];
    tp_we    = 1'b0;
    tp_waddr = dp_r;
    tp_wdata = 8'd0;
    q_we     = 1'b0;

    case (state_r)
      ST_CLR: begin
        tp_we    = 1'b1;
        tp_waddr = clr_r;
        clr_nxt  = clr_r + 12'd1;
        if (&clr_r) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          res_ev_nxt   = tme_pkg::EV_DONE;
          res_data_nxt = 8'd0;
          res_epos_nxt = 13'd0;
          state_nxt    = ST_RESP;
          case (in_op)
            tme_pkg::OP_LOAD: begin
              pm_we = 1'b1;
              if ({1'b0, in_address} + 13'd1 > len_r) begin
                len_nxt = {1'b0, in_address} + 13'd1;
              end
            end
            tme_pkg::OP_QUEUE: begin
              if (cnt_r == 5'(tme_pkg::QueueDepth)) begin
                res_ev_nxt = tme_pkg::EV_FULL;
              end else begin
                q_we    = 1'b1;
                cnt_nxt = cnt_r + 5'd1;
              end
            end
            tme_pkg::OP_EXEC: begin
              if (pc_r >= len_r) begin
                res_ev_nxt = tme_pkg::EV_END;
              end else begin
                state_nxt = ST_EXEC;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_EXEC: begin
        state_nxt = ST_RESP;
        pc_nxt    = pc_r + 13'd1;
        if (ins == tme_pkg::INS_INC) begin
          tp_we    = 1'b1;
          tp_wdata = cur_cell + 8'd1;
        end else if (ins == tme_pkg::INS_DEC) begin
          tp_we    = 1'b1;
          tp_wdata = cur_cell - 8'd1;
        end else if (ins == tme_pkg::INS_RIGHT) begin
          if ({1'b0, dp_r} + 13'd1 >= size_eff) begin
            dp_nxt = wrap_r ? 12'd0 : size_m1;
          end else begin
            dp_nxt = dp_r + 12'd1;
          end
        end else if (ins == tme_pkg::INS_LEFT) begin
          if (dp_r == 12'd0) begin
            if (wrap_r) begin
              dp_nxt = size_m1;
            end
          end else begin
            dp_nxt = dp_r - 12'd1;
          end
        end else if (ins == tme_pkg::INS_OUT) begin
          res_ev_nxt   = tme_pkg::EV_OUT;
          res_data_nxt = cur_cell;
        end else if (ins == tme_pkg::INS_IN) begin
          if (cnt_r == 5'd0) begin
            res_ev_nxt = tme_pkg::EV_WAIT;
            pc_nxt     = pc_r;
          end else begin
            tp_we    = 1'b1;
            tp_wdata = q_r[head_r];
            head_nxt = head_r + 4'd1;
            cnt_nxt  = cnt_r - 5'd1;
          end
        end else if (ins == tme_pkg::INS_OPEN) begin
          if (cur_cell == 8'd0) begin
            pc_nxt       = pc_r;
            scan_p_nxt   = pc_r;
            scan_dep_nxt = 13'd1;
            scan_fwd_nxt = 1'b1;
            state_nxt    = ST_SRD;
          end
        end else if (ins == tme_pkg::INS_CLOSE) begin
          if (cur_cell != 8'd0) begin
            pc_nxt       = pc_r;
            scan_p_nxt   = pc_r;
            scan_dep_nxt = 13'd1;
            scan_fwd_nxt = 1'b0;
            state_nxt    = ST_SRD;
          end
        end else if (ins == stop_r) begin
          res_ev_nxt = tme_pkg::EV_HALT;
          pc_nxt     = pc_r;
        end else if (ext_r) begin
          if (ins == copy0_r) begin
            tp_we    = 1'b1;
            tp_waddr = 12'd0;
            tp_wdata = cur_cell;
          end else if (ins == copy1_r) begin
            tp_we    = 1'b1;
            tp_waddr = 12'd1;
            tp_wdata = cur_cell;
          end else if (ins == pclr_r) begin
            dp_nxt = 12'd0;
          end else if (ins == pswap_r) begin
            dp_nxt = sp_r;
            sp_nxt = dp_r;
          end
        end
      end
      ST_SRD: begin
        // Step the scan position and fetch the byte there, or stop at an end
        if ((scan_fwd_r && step_p >= len_r) || (!scan_fwd_r && scan_p_r == 13'd0)) begin
          res_ev_nxt   = tme_pkg::EV_JUMP;
          res_epos_nxt = pc_r + 13'd1;
          state_nxt    = ST_RESP;
        end else begin
          scan_p_nxt = step_p;
          pm_raddr   = step_p[11:0];
          state_nxt  = ST_SCHK;
        end
      end
      ST_SCHK: begin
        scan_dep_nxt = dep_new;
        if (dep_new == 13'd0) begin
          pc_nxt    = scan_p_r + 13'd1;
          state_nxt = ST_RESP;
        end else begin
          state_nxt = ST_SRD;
        end
      end
      ST_RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_ev_nxt    = res_ev_r;
          out_data_nxt  = res_data_r;
          out_epos_nxt  = res_epos_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_r       <= 12'd0;
      pc_r        <= 13'd0;
      len_r       <= 13'd0;
      dp_r        <= 12'd0;
      sp_r        <= 12'd0;
      head_r      <= 4'd0;
      cnt_r       <= 5'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      pc_r        <= pc_nxt;
      len_r       <= len_nxt;
      dp_r        <= dp_nxt;
      sp_r        <= sp_nxt;
      head_r      <= head_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    scan_p_r   <= scan_p_nxt;
    scan_dep_r <= scan_dep_nxt;
    scan_fwd_r <= scan_fwd_nxt;
    res_ev_r   <= res_ev_nxt;
    res_data_r <= res_data_nxt;
    res_epos_r <= res_epos_nxt;
    out_ev_r   <= out_ev_nxt;
    out_data_r <= out_data_nxt;
    out_epos_r <= out_epos_nxt;
    if (q_we) begin
      q_r[4'(head_r + cnt_r[3:0])] <= in_value;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wrap_r  <= 1'b0;
      ext_r   <= 1'b1;
      tsize_r <= 13'd4096;
      copy0_r <= 8'd48;
      copy1_r <= 8'd49;
      stop_r  <= 8'd35;
      pclr_r  <= 8'd94;
      pswap_r <= 8'd120;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tme_pkg::REG_WRAP:  wrap_r  <= cfg_data[0];
        tme_pkg::REG_EXT:   ext_r   <= cfg_data[0];
        tme_pkg::REG_SIZE:  tsize_r <= cfg_data;
        tme_pkg::REG_COPY0: copy0_r <= cfg_data[7:0];
        tme_pkg::REG_COPY1: copy1_r <= cfg_data[7:0];
        tme_pkg::REG_STOP:  stop_r  <= cfg_data[7:0];
        tme_pkg::REG_PCLR:  pclr_r  <= cfg_data[7:0];
        tme_pkg::REG_PSWAP: pswap_r <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  // Program store: one write and one registered read
  always_ff @(posedge clk) begin
    if (pm_we) begin
      pm[in_address] <= in_value;
    end
    pm_rdata_r <= pm[pm_raddr];
  end

  // Tape: one write and one registered read at the data pointer
  always_ff @(posedge clk) begin
    if (tp_we) begin
      tape[tp_waddr] <= tp_wdata;
    end
    tp_rdata_r <= tape[dp_r];
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 5'(tme_pkg::QueueDepth))
    else $error("input queue count beyond depth");

  a_clr_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLR) |-> in_stall)
    else $error("item accepted during tape clear");

  a_data_ev: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_ev_r == tme_pkg::EV_OUT || out_data_r == 8'd0))
    else $error("output byte without output event");

  a_epos_ev: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_ev_r == tme_pkg::EV_JUMP || out_epos_r == 13'd0))
    else $error("error position without jump error");

  a_scan_dep: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SRD || state_r == ST_SCHK) |-> (scan_dep_r != 13'd0))
    else $error("bracket scan running at depth zero");
`endif

endmodule
`default_nettype wire

// ===== dv/tape_machine_instruction_executor_test.sv =====
// Self-checking testbench for the tape machine instruction executor.
`default_nettype none
module tape_machine_instruction_executor_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Clock and reset
  logic clk;
  logic rst_n;

  // Input channel
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_op;
  logic [11:0] in_address;
  logic [7:0]  in_value;

  // Result channel
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_event_res;
  logic [7:0]  out_data;
  logic [12:0] out_error_position;

  // Configuration channel
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [12:0] cfg_data;

  tape_machine_instruction_executor u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_op(in_op),
    .in_address(in_address), .in_value(in_value),
    .out_valid(out_valid), .out_stall(out_stall), .out_event_res(out_event_res),
    .out_data(out_data), .out_error_position(out_error_position),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  typedef struct packed {
    logic [2:0]  ev;
    logic [7:0]  data;
    logic [12:0] errpos;
  } result_t;

  typedef struct {
    logic [1:0]  op;
    logic [11:0] address;
    logic [7:0]  value;
    bit          typed;
    result_t     res;
  } row_t;

  // Model copy of the configuration
  bit         m_wrap;
  bit         m_ext;
  int unsigned m_size;
  logic [7:0] m_copy0, m_copy1, m_stop, m_pclr, m_pswap;

  // Model copy of the state
  logic [7:0]  m_prog [tme_pkg::ProgDepth];
  int unsigned m_len, m_pc, m_dp, m_sp;
  logic [7:0]  m_tape [tme_pkg::TapeDepth];
  logic [7:0]  m_queue [tme_pkg::QueueDepth];
  int unsigned m_qhead, m_qcount;

  result_t expected_results[$];
  int      mismatches;
  longint  cycles = 0;
  int      n_sent;
  int      send_idle_pct;
  int      recv_stall_pct;

  // Clock generation
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 64'd20_000_000) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic int unsigned effective_size();
    if (m_size == 0) return 1;
    if (m_size > tme_pkg::TapeDepth) return tme_pkg::TapeDepth;
    return m_size;
  endfunction

  function automatic void write_register(logic [2:0] idx, logic [12:0] val);
    case (idx)
      tme_pkg::REG_WRAP:  m_wrap = val[0];
      tme_pkg::REG_EXT:   m_ext = val[0];
      tme_pkg::REG_SIZE:  m_size = 32'(val);
      tme_pkg::REG_COPY0: m_copy0 = val[7:0];
      tme_pkg::REG_COPY1: m_copy1 = val[7:0];
      tme_pkg::REG_STOP:  m_stop = val[7:0];
      tme_pkg::REG_PCLR:  m_pclr = val[7:0];
      default:            m_pswap = val[7:0];
    endcase
  endfunction

  // Predicts the result of one word and advances the model state.
  function automatic result_t execute_word(logic [1:0] op, logic [11:0] addr,
                                           logic [7:0] val);
    result_t r;
    logic [7:0] ins;
    int unsigned sz, p, depth, t;
    bit advance, ok;
    r = '0;
    r.ev = tme_pkg::EV_DONE;
    if (op == tme_pkg::OP_LOAD) begin
      m_prog[addr] = val;
      if (addr + 1 > m_len) m_len = addr + 1;
    end else if (op == tme_pkg::OP_QUEUE) begin
      if (m_qcount >= tme_pkg::QueueDepth) r.ev = tme_pkg::EV_FULL;
      else begin
        m_queue[(m_qhead + m_qcount) % tme_pkg::QueueDepth] = val;
        m_qcount++;
      end
    end else if (op == tme_pkg::OP_EXEC) begin
      if (m_pc >= m_len) r.ev = tme_pkg::EV_END;
      else begin
        ins = m_prog[m_pc];
        sz = effective_size();
        advance = 1'b1;
        if (ins == tme_pkg::INS_INC) m_tape[m_dp] = m_tape[m_dp] + 8'd1;
        else if (ins == tme_pkg::INS_DEC) m_tape[m_dp] = m_tape[m_dp] - 8'd1;
        else if (ins == tme_pkg::INS_RIGHT) begin
          if (m_dp + 1 >= sz) m_dp = m_wrap ? 0 : sz - 1;
          else m_dp++;
        end else if (ins == tme_pkg::INS_LEFT) begin
          if (m_dp == 0) begin
            if (m_wrap) m_dp = sz - 1;
          end else m_dp--;
        end else if (ins == tme_pkg::INS_OUT) begin
          r.ev = tme_pkg::EV_OUT;
          r.data = m_tape[m_dp];
        end else if (ins == tme_pkg::INS_IN) begin
          if (m_qcount == 0) begin
            r.ev = tme_pkg::EV_WAIT;
            advance = 1'b0;
          end else begin
            m_tape[m_dp] = m_queue[m_qhead];
            m_qhead = (m_qhead + 1) % tme_pkg::QueueDepth;
            m_qcount--;
          end
        end else if (ins == tme_pkg::INS_OPEN || ins == tme_pkg::INS_CLOSE) begin
          if ((ins == tme_pkg::INS_OPEN) == (m_tape[m_dp] == 8'd0)) begin
            p = m_pc;
            depth = 1;
            ok = 1'b1;
            while (depth != 0 && ok) begin
              if (ins == tme_pkg::INS_OPEN) begin
                p++;
                if (p >= m_len) ok = 1'b0;
              end else if (p == 0) ok = 1'b0;
              else p--;
              if (ok) begin
                if (m_prog[p] == tme_pkg::INS_OPEN)
                  depth = (ins == tme_pkg::INS_OPEN) ? depth + 1 : depth - 1;
                else if (m_prog[p] == tme_pkg::INS_CLOSE)
                  depth = (ins == tme_pkg::INS_OPEN) ? depth - 1 : depth + 1;
              end
            end
            if (ok) m_pc = p;
            else begin
              r.ev = tme_pkg::EV_JUMP;
              r.errpos = 13'(m_pc + 1);
              advance = 1'b0;
            end
          end
        end else if (ins == m_stop) begin
          r.ev = tme_pkg::EV_HALT;
          advance = 1'b0;
        end else if (m_ext) begin
          if (ins == m_copy0) m_tape[0] = m_tape[m_dp];
          else if (ins == m_copy1) m_tape[1] = m_tape[m_dp];
          else if (ins == m_pclr) m_dp = 0;
          else if (ins == m_pswap) begin
            t = m_dp;
            m_dp = m_sp;
            m_sp = t;
          end
        end
        if (advance) m_pc++;
      end
    end
    return r;
  endfunction

  // Sends one word; the expectation is queued at acceptance. Valid stays
  // high after acceptance so that words can follow back to back.
  task automatic send_word(logic [1:0] op, logic [11:0] addr, logic [7:0] val,
                           bit typed, result_t typed_res);
    result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_address <= addr;
    in_value <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = execute_word(op, addr, val);
    n_sent++;
    if (typed && r != typed_res) begin
      mismatches++;
      if (mismatches <= 10)
        $display("table row disagrees with model: table %h model %h", typed_res, r);
    end
    expected_results.push_back(r);
  endtask

  // Waits until every expected word has arrived, plus a settling gap.
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic configure(logic [2:0] idx, logic [12:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    write_register(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Result checker and stall generator
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", out_event_res);
      end else begin
        want = expected_results.pop_front();
        if (out_event_res !== want.ev || out_data !== want.data ||
            out_error_position !== want.errpos) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected ev %0d data %0d pos %0d, got %0d %0d %0d",
                     want.ev, want.data, want.errpos,
                     out_event_res, out_data, out_error_position);
        end
      end
    end
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Random program chunk: a random body, then a burst of executions mixed with queue words and the unused op
  task automatic random_program();
    logic [7:0] alphabet [12];
    int n, base;
    logic [7:0] b;
    alphabet = '{tme_pkg::INS_INC, tme_pkg::INS_DEC, tme_pkg::INS_RIGHT,
                 tme_pkg::INS_LEFT, tme_pkg::INS_OUT, tme_pkg::INS_IN,
                 m_stop, m_copy0, m_copy1, m_pclr, m_pswap, 8'h41};
    base = m_len;
    if (base > tme_pkg::ProgDepth - 40) base = $urandom_range(0, 200);
    n = $urandom_range(3, 12);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0: b = tme_pkg::INS_OPEN;
        1: b = tme_pkg::INS_CLOSE;
        2: b = 8'($urandom_range(255));
        default: b = alphabet[$urandom_range(11)];
      endcase
      send_word(tme_pkg::OP_LOAD, 12'(base + i), b, 1'b0, '0);
    end
    // A halt or a bracket, which may be unmatched, at the program counter could stop
    // progress for good, so replace it with a plain increment.
    if (m_pc < m_len && (m_prog[m_pc] == m_stop || m_prog[m_pc] == tme_pkg::INS_OPEN ||
                         m_prog[m_pc] == tme_pkg::INS_CLOSE))
      send_word(tme_pkg::OP_LOAD, 12'(m_pc), tme_pkg::INS_INC, 1'b0, '0);
    for (int i = 0; i < n + 4; i++) begin
      if ($urandom_range(5) == 0)
        send_word(tme_pkg::OP_QUEUE, 12'($urandom), 8'($urandom), 1'b0, '0);
      else if ($urandom_range(30) == 0)
        send_word(2'd3, 12'($urandom), 8'($urandom), 1'b0, '0);
      else send_word(tme_pkg::OP_EXEC, 12'd0, 8'd0, 1'b0, '0);
    end
  endtask

  initial begin
    row_t table_rows[$];
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = tme_pkg::OP_LOAD;
    in_address = '0;
    in_value = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = tme_pkg::REG_WRAP;
    cfg_data = '0;
    mismatches = 0;
    n_sent = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    m_wrap = 0; m_ext = 1; m_size = 4096;
    m_copy0 = 8'd48; m_copy1 = 8'd49; m_stop = 8'd35; m_pclr = 8'd94; m_pswap = 8'd120;
    m_len = 0; m_pc = 0; m_dp = 0; m_sp = 0; m_qhead = 0; m_qcount = 0;
    foreach (m_tape[i]) m_tape[i] = '0;
    foreach (m_prog[i]) m_prog[i] = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: reset state, extremes and special cases
    table_rows = '{
      '{tme_pkg::OP_EXEC, 12'd0, 8'd0, 1, '{tme_pkg::EV_END, 8'd0, 13'd0}},
      '{2'd3, 12'hFFF, 8'hFF, 1, '{tme_pkg::EV_DONE, 8'd0, 13'd0}},
      '{tme_pkg::OP_LOAD, 12'd0, tme_pkg::INS_CLOSE, 1, '{tme_pkg::EV_DONE, 8'd0, 13'd0}},
      '{tme_pkg::OP_LOAD, 12'd1, tme_pkg::INS_OPEN, 1, '{tme_pkg::EV_DONE, 8'd0, 13'd0}},
      '{tme_pkg::OP_LOAD, 12'd2, tme_pkg::INS_DEC, 1, '{tme_pkg::EV_DONE, 8'd0, 13'd0}},
      '{tme_pkg::OP_LOAD, 12'd3, tme_pkg::INS_OUT, 1, '{tme_pkg::EV_DONE, 8'd0, 13'd0}},
      '{tme_pkg::OP_LOAD, 12'd4, tme_pkg::INS_LEFT, 1, '{tme_pkg::EV_DONE, 8'd0, 13'd0}},
      '{tme_pkg::OP_LOAD, 12'd5, tme_pkg::INS_IN, 1, '{tme_pkg::EV_DONE, 8'd0, 13'd0}},
      '{tme_pkg::OP_LOAD, 12'd6, 8'd35, 1, '{tme_pkg::EV_DONE, 8'd0, 13'd0}},
      '{tme_pkg::OP_EXEC, 12'd0, 8'd0, 1, '{tme_pkg::EV_DONE, 8'd0, 13'd0}},
      '{tme_pkg::OP_EXEC, 12'd0, 8'd0, 1, '{tme_pkg::EV_JUMP, 8'd0, 13'd2}},
      '{tme_pkg::OP_LOAD, 12'd1, tme_pkg::INS_RIGHT, 0, '{tme_pkg::EV_DONE, 8'd0, 13'd0}},
      '{tme_pkg::OP_EXEC, 12'd0, 8'd0, 0, '{tme_pkg::EV_DONE, 8'd0, 13'd0}},
      '{tme_pkg::OP_EXEC, 12'd0, 8'd0, 0, '{tme_pkg::EV_DONE, 8'd0, 13'd0}},
      '{tme_pkg::OP_EXEC, 12'd0, 8'd0, 1, '{tme_pkg::EV_OUT, 8'hFF, 13'd0}},
      '{tme_pkg::OP_EXEC, 12'd0, 8'd0, 0, '{tme_pkg::EV_DONE, 8'd0, 13'd0}},
      '{tme_pkg::OP_EXEC, 12'd0, 8'd0, 1, '{tme_pkg::EV_WAIT, 8'd0, 13'd0}},
      '{tme_pkg::OP_QUEUE, 12'hFFF, 8'hFF, 1, '{tme_pkg::EV_DONE, 8'd0, 13'd0}},
      '{tme_pkg::OP_EXEC, 12'd0, 8'd0, 1, '{tme_pkg::EV_DONE, 8'd0, 13'd0}},
      '{tme_pkg::OP_EXEC, 12'd0, 8'd0, 1, '{tme_pkg::EV_HALT, 8'd0, 13'd0}}
    };
    foreach (table_rows[i])
      send_word(table_rows[i].op, table_rows[i].address, table_rows[i].value,
                table_rows[i].typed, table_rows[i].res);
    // Fill the input queue until it reports full
    for (int i = 0; i < 17; i++) send_word(tme_pkg::OP_QUEUE, 12'h000, 8'h00, 1'b0, '0);
    drain();

    // Random part across configuration settings and idling phases
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 83; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 83; end
        default: begin send_idle_pct = 22; recv_stall_pct = 22; end
      endcase
      drain();
      configure(tme_pkg::REG_WRAP, ph[0] ? 13'd1 : 13'd0);
      configure(tme_pkg::REG_EXT, (ph == 3) ? 13'd0 : 13'd1);
      case (ph)
        0: configure(tme_pkg::REG_SIZE, 13'd1);
        1: configure(tme_pkg::REG_SIZE, 13'd0);
        2: configure(tme_pkg::REG_SIZE, 13'h1FFF);
        3: configure(tme_pkg::REG_SIZE, 13'd4096);
        default: configure(tme_pkg::REG_SIZE, 13'($urandom_range(2, 6)));
      endcase
      configure(tme_pkg::REG_COPY0, (ph == 5) ? 13'd0 : 13'd48);
      configure(tme_pkg::REG_COPY1, (ph == 5) ? 13'd255 : 13'd49);
      configure(tme_pkg::REG_STOP, (ph == 6) ? 13'd255 : 13'd35);
      configure(tme_pkg::REG_PCLR, (ph == 6) ? 13'd0 : 13'd94);
      configure(tme_pkg::REG_PSWAP, (ph == 7) ? {5'd0, tme_pkg::INS_INC} : 13'd120);
      while (n_sent < 38 + (ph + 1) * 139) begin
        random_program();
        if (ph == 4 && n_sent % 300 < 30) drain();
      end
    end

    // Load at the top program address last, so no execution runs over
    // the unwritten bytes below it
    drain();
    send_word(tme_pkg::OP_LOAD, 12'hFFF, 8'd0, 1'b1, '{tme_pkg::EV_DONE, 8'd0, 13'd0});
    drain();
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire
